// File: design/ole_pkg.sv
package ole_pkg;

  localparam int CAPACITY_DEF   = 16;
  localparam int DATA_WIDTH_DEF = 32;
  // cell index width for the largest supported list
  localparam int IDX_MAX_W      = 8;

  localparam logic [3:0] OP_PUSH_FRONT   = 4'd0;
  localparam logic [3:0] OP_PUSH_BACK    = 4'd1;
  localparam logic [3:0] OP_POP_FRONT    = 4'd2;
  localparam logic [3:0] OP_POP_BACK     = 4'd3;
  localparam logic [3:0] OP_INSERT       = 4'd4;
  localparam logic [3:0] OP_DELETE_AT    = 4'd5;
  localparam logic [3:0] OP_DELETE_VALUE = 4'd6;
  localparam logic [3:0] OP_FIND         = 4'd7;
  localparam logic [3:0] OP_READ         = 4'd8;

  localparam logic [2:0] STAT_OK        = 3'd0;
  localparam logic [2:0] STAT_EMPTY     = 3'd1;
  localparam logic [2:0] STAT_FULL      = 3'd2;
  localparam logic [2:0] STAT_BAD_POS   = 3'd3;
  localparam logic [2:0] STAT_NOT_FOUND = 3'd4;

  typedef struct packed {
    logic [3:0]         op;
    logic signed [31:0] item_value;
    logic [4:0]         position;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] data_out;
    logic [3:0]         found_index;
    logic [2:0]         status;
    logic [4:0]         entry_count;
  } out_word_t;

  typedef struct packed {
    logic                 ins;
    logic                 del;
    logic                 scan_start;
    logic                 scan_step;
    logic [IDX_MAX_W-1:0] tgt;
  } cell_ctrl_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_SCAN = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

endpackage

// File: design/ole_cell.sv
module ole_cell #(
  parameter int DATA_WIDTH = ole_pkg::DATA_WIDTH_DEF,
  parameter int IDX        = 0
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ole_pkg::cell_ctrl_t   ctrl,
  input  logic [DATA_WIDTH-1:0] ins_val,
  input  logic [DATA_WIDTH-1:0] left_data,
  input  logic [DATA_WIDTH-1:0] right_data,
  input  logic                  left_probe,
  output logic [DATA_WIDTH-1:0] data,
  output logic [DATA_WIDTH-1:0] rd_data,
  output logic                  probe,
  output logic                  match
);
  import ole_pkg::*;

  localparam logic [IDX_MAX_W-1:0] MY_IDX = IDX_MAX_W'(IDX);

  logic [DATA_WIDTH-1:0] data_r, data_nxt;
  logic                  probe_r, probe_nxt;

  always_comb begin
    data_nxt = data_r;
    if (ctrl.ins) begin
      if (MY_IDX > ctrl.tgt) begin
        data_nxt = left_data;
      end else if (MY_IDX == ctrl.tgt) begin
        data_nxt = ins_val;
      end
    end else if (ctrl.del) begin
      if (MY_IDX >= ctrl.tgt) begin
        data_nxt = right_data;
      end
    end
  end

  always_comb begin
    priority if (ctrl.scan_start) begin
      probe_nxt = (MY_IDX == '0);
    end else if (ctrl.scan_step) begin
      probe_nxt = left_probe;
    end else begin
      probe_nxt = probe_r;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      probe_r <= 1'b0;
    end else begin
      probe_r <= probe_nxt;
    end
  end

  assign data    = data_r;
  assign rd_data = (MY_IDX == ctrl.tgt) ? data_r : '0;
  assign probe   = probe_r;
  assign match   = probe_r && (data_r == ins_val);

endmodule

// File: design/ole_ctrl.sv
module ole_ctrl #(
  parameter int CAPACITY   = ole_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = ole_pkg::DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  ole_pkg::in_word_t     in_word,
  output logic                  out_valid,
  input  logic                  out_stall,
  output ole_pkg::out_word_t    out_word,
  output ole_pkg::cell_ctrl_t   cell_ctrl,
  output logic [DATA_WIDTH-1:0] ins_val,
  input  logic [DATA_WIDTH-1:0] rd_data,
  input  logic                  hit
);
  import ole_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;

  state_t                state_r, state_nxt;
  logic [3:0]            op_r, op_nxt;
  logic [DATA_WIDTH-1:0] val_r, val_nxt;
  logic [4:0]            pos_r, pos_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [IDX_W-1:0]      k_r, k_nxt;
  out_word_t             res_r, res_nxt;
  out_word_t             out_r, out_nxt;
  logic                  out_valid_r, out_valid_nxt;

  logic signed [63:0]           in_ext;
  logic signed [DATA_WIDTH-1:0] rd_s;
  logic signed [63:0]           rd_ext;
  logic [CMP_W-1:0]             cnt_x, pos_x, k_x, cnt_nxt_x;
  logic [IDX_MAX_W-1:0]         k_t;
  logic                         full, empty;
  logic                         finish;
  logic signed [31:0]           data_v;
  logic [2:0]                   stat_v;
  logic                         idx_sel;

  assign in_ext    = 64'(in_word.item_value);
  assign rd_s      = rd_data;
  assign rd_ext    = 64'(rd_s);
  assign cnt_x     = CMP_W'(cnt_r);
  assign pos_x     = CMP_W'(pos_r);
  assign k_x       = CMP_W'(k_r);
  assign cnt_nxt_x = CMP_W'(cnt_nxt);
  assign k_t       = IDX_MAX_W'(k_r);
  assign full      = (cnt_r == CNT_W'(CAPACITY));
  assign empty     = (cnt_r == '0);

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    val_nxt       = val_r;
    pos_nxt       = pos_r;
    cnt_nxt       = cnt_r;
    k_nxt         = k_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    cell_ctrl     = '0;
    finish        = 1'b0;
    data_v        = '0;
    stat_v        = STAT_OK;
    idx_sel       = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_word.op;
          val_nxt   = in_ext[DATA_WIDTH-1:0];
          pos_nxt   = in_word.position;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        finish = 1'b1;
        unique case (op_r)
          OP_PUSH_FRONT, OP_PUSH_BACK: begin
            if (full) begin
              stat_v = STAT_FULL;
            end else begin
              cell_ctrl.ins = 1'b1;
              cell_ctrl.tgt = (op_r == OP_PUSH_FRONT) ? '0 : IDX_MAX_W'(cnt_r);
              cnt_nxt       = cnt_r + 1'b1;
            end
          end
          OP_POP_FRONT, OP_POP_BACK: begin
            if (empty) begin
              stat_v = STAT_EMPTY;
            end else begin
              cell_ctrl.del = 1'b1;
              cell_ctrl.tgt = (op_r == OP_POP_FRONT) ? '0 : IDX_MAX_W'(cnt_r - 1'b1);
              data_v        = rd_ext[31:0];
              cnt_nxt       = cnt_r - 1'b1;
            end
          end
          OP_INSERT: begin
            if (full) begin
              stat_v = STAT_FULL;
            end else if (pos_x > cnt_x) begin
              stat_v = STAT_BAD_POS;
            end else begin
              cell_ctrl.ins = 1'b1;
              cell_ctrl.tgt = IDX_MAX_W'(pos_r);
              cnt_nxt       = cnt_r + 1'b1;
            end
          end
          OP_DELETE_AT, OP_READ: begin
            cell_ctrl.tgt = IDX_MAX_W'(pos_r);
            if (empty) begin
              stat_v = STAT_EMPTY;
            end else if (pos_x >= cnt_x) begin
              stat_v = STAT_BAD_POS;
            end else if (op_r == OP_DELETE_AT) begin
              cell_ctrl.del = 1'b1;
              cnt_nxt       = cnt_r - 1'b1;
            end else begin
              data_v = rd_ext[31:0];
            end
          end
          OP_DELETE_VALUE, OP_FIND: begin
            if (empty) begin
              stat_v = STAT_EMPTY;
            end else begin
              finish               = 1'b0;
              cell_ctrl.scan_start = 1'b1;
              k_nxt                = '0;
              state_nxt            = S_SCAN;
            end
          end
          default: begin
          end
        endcase
      end
      S_SCAN: begin
        cell_ctrl.tgt = k_t;
        if (hit) begin
          finish = 1'b1;
          if (op_r == OP_DELETE_VALUE) begin
            cell_ctrl.del = 1'b1;
            cnt_nxt       = cnt_r - 1'b1;
          end else begin
            idx_sel = 1'b1;
          end
        end else if (k_x == cnt_x - 1'b1) begin
          finish = 1'b1;
          stat_v = STAT_NOT_FOUND;
        end else begin
          cell_ctrl.scan_step = 1'b1;
          k_nxt               = k_r + 1'b1;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (finish) begin
      state_nxt           = S_DONE;
      res_nxt.data_out    = data_v;
      res_nxt.found_index = idx_sel ? k_t[3:0] : 4'd0;
      res_nxt.status      = stat_v;
      res_nxt.entry_count = cnt_nxt_x[4:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    val_r <= val_nxt;
    pos_r <= pos_nxt;
    k_r   <= k_nxt;
    res_r <= res_nxt;
    out_r <= out_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_r;
  assign ins_val   = val_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (k_x < cnt_x))
    else $error("scan probe beyond last entry");

  a_cnt_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_DONE) |=> $stable(cnt_r))
    else $error("count changed outside execution");

  a_done_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && !(out_valid_r && out_stall)) |=>
      (out_valid_r && state_r == S_IDLE))
    else $error("finished result not moved to output");

endmodule

// File: design/ordered_list_engine.sv
// channel  ports                        word type   accepted when
// input    in_valid / in_stall          in_word_t   in_valid && !in_stall
// result   out_valid / out_stall        out_word_t  out_valid && !out_stall
//
// Push, pop, insert, delete at and read: the word is registered, the result is
//   registered, then moved to the output register once that is free.
// Find and delete value: a scan state runs until a match or the last entry;
//   the probe bit walks one cell per cycle down the chain.
// One word is in work at a time; the next is taken once the result is in out_r.
// Synchronous active-low reset empties the list; entry storage is not cleared.
// A stalled result holds in the output register while the next word is taken.
module ordered_list_engine #(
  parameter int CAPACITY   = ole_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = ole_pkg::DATA_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ole_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output ole_pkg::out_word_t out_word
);
  import ole_pkg::*;

  cell_ctrl_t            cell_ctrl;
  logic [DATA_WIDTH-1:0] ins_val;
  logic [DATA_WIDTH-1:0] data_vec  [CAPACITY];
  logic [DATA_WIDTH-1:0] rd_vec    [CAPACITY];
  logic                  probe_vec [CAPACITY];
  logic [CAPACITY-1:0]   match_vec;
  logic [DATA_WIDTH-1:0] rd_data;
  logic                  hit;

  ole_ctrl #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cell_ctrl (cell_ctrl),
    .ins_val   (ins_val),
    .rd_data   (rd_data),
    .hit       (hit)
  );

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_d, right_d;
    logic                  left_p;

    if (g == 0) begin : g_first
      assign left_d = ins_val;
      assign left_p = 1'b0;
    end else begin : g_mid
      assign left_d = data_vec[g-1];
      assign left_p = probe_vec[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign right_d = data_vec[g];
    end else begin : g_inner
      assign right_d = data_vec[g+1];
    end

    ole_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .IDX        (g)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (cell_ctrl),
      .ins_val    (ins_val),
      .left_data  (left_d),
      .right_data (right_d),
      .left_probe (left_p),
      .data       (data_vec[g]),
      .rd_data    (rd_vec[g]),
      .probe      (probe_vec[g]),
      .match      (match_vec[g])
    );
  end

  always_comb begin
    rd_data = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_data = rd_data | rd_vec[i];
    end
  end

  assign hit = |match_vec;

endmodule

// File: sim/ordered_list_engine_tb.sv
module ordered_list_engine_tb;
  import ole_pkg::*;

  localparam int LIST_CAP = CAPACITY_DEF;
  localparam int LIMIT_CYCLES = 200000;
  localparam int HOLD_CYCLES = 60;
  localparam int DRAIN_CYCLES = 40;
  localparam int WORDS_PER_PHASE = 68;

  localparam logic [3:0] OP_UNUSED_LO = 4'd9;
  localparam logic [3:0] OP_UNUSED_HI = 4'hF;

  typedef enum int {MIX_OPS, GROW_LIST, DRAIN_LIST} op_mix_t;

  localparam logic [3:0] GROW_OPS [3] = '{OP_PUSH_FRONT, OP_PUSH_BACK, OP_INSERT};
  localparam logic [3:0] DRAIN_OPS [4] = '{OP_POP_FRONT, OP_POP_BACK, OP_DELETE_AT,
                                           OP_DELETE_VALUE};

  localparam op_mix_t PHASE_MIX [6] = '{MIX_OPS, GROW_LIST, MIX_OPS, DRAIN_LIST,
                                        GROW_LIST, MIX_OPS};
  localparam int SRC_IDLE_PCT [6] = '{30, 0, 0, 50, 10, 0};
  localparam int SINK_BUSY_PCT [6] = '{30, 0, 20, 10, 50, 0};

  typedef struct packed {
    logic [3:0]         op;
    logic signed [31:0] val;
    logic [4:0]         pos;
    logic [4:0]         reps;
    logic               fixed;
    logic signed [31:0] data;
    logic [3:0]         idx;
    logic [2:0]         st;
    logic [4:0]         cnt;
  } stim_row_t;

  // fixed = 1: typed result, else predicted
  localparam int NUM_ROWS = 28;
  localparam stim_row_t DIRECTED_ROWS [NUM_ROWS] = '{
    '{OP_POP_FRONT,    0,             0,  1, 1, 0,             0, STAT_EMPTY,     0},
    '{OP_POP_BACK,     0,             0,  1, 1, 0,             0, STAT_EMPTY,     0},
    '{OP_DELETE_AT,    0,             0,  1, 1, 0,             0, STAT_EMPTY,     0},
    '{OP_DELETE_VALUE, 5,             0,  1, 1, 0,             0, STAT_EMPTY,     0},
    '{OP_FIND,         5,             0,  1, 1, 0,             0, STAT_EMPTY,     0},
    '{OP_READ,         0,             31, 1, 1, 0,             0, STAT_EMPTY,     0},
    '{OP_INSERT,       9,             1,  1, 1, 0,             0, STAT_BAD_POS,   0},
    '{OP_INSERT,       32'sh7FFFFFFF, 0,  1, 1, 0,             0, STAT_OK,        1},
    '{OP_PUSH_FRONT,   32'sh80000000, 0,  1, 1, 0,             0, STAT_OK,        2},
    '{OP_PUSH_BACK,    -1,            0,  1, 1, 0,             0, STAT_OK,        3},
    '{OP_INSERT,       42,            3,  1, 1, 0,             0, STAT_OK,        4},
    '{OP_INSERT,       17,            2,  1, 0, 0,             0, STAT_OK,        0},
    '{OP_READ,         0,             0,  1, 1, 32'sh80000000, 0, STAT_OK,        5},
    '{OP_READ,         0,             4,  1, 0, 0,             0, STAT_OK,        0},
    '{OP_READ,         0,             5,  1, 1, 0,             0, STAT_BAD_POS,   5},
    '{OP_FIND,         -1,            0,  1, 0, 0,             0, STAT_OK,        0},
    '{OP_FIND,         7,             0,  1, 1, 0,             0, STAT_NOT_FOUND, 5},
    '{OP_DELETE_VALUE, 12345,         0,  1, 1, 0,             0, STAT_NOT_FOUND, 5},
    '{OP_DELETE_VALUE, 32'sh80000000, 0,  1, 0, 0,             0, STAT_OK,        0},
    '{OP_DELETE_AT,    0,             1,  1, 0, 0,             0, STAT_OK,        0},
    '{OP_POP_FRONT,    0,             0,  1, 0, 0,             0, STAT_OK,        0},
    '{OP_POP_BACK,     0,             0,  1, 0, 0,             0, STAT_OK,        0},
    '{OP_UNUSED_HI,    -1,            31, 1, 0, 0,             0, STAT_OK,        0},
    '{OP_PUSH_BACK,    32'sh0F0F0F0F, 16, 15, 0, 0,            0, STAT_OK,        0},
    '{OP_PUSH_FRONT,   1,             0,  1, 1, 0,             0, STAT_FULL,      16},
    '{OP_INSERT,       1,             31, 1, 1, 0,             0, STAT_FULL,      16},
    '{OP_READ,         0,             15, 1, 0, 0,             0, STAT_OK,        0},
    '{OP_FIND,         32'sh0F0F0F0F, 0,  1, 0, 0,             0, STAT_OK,        0}
  };

  logic      clk;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;

  logic signed [31:0] shadow_list [$];
  out_word_t          awaited_results [$];
  out_word_t          head_result;
  int                 mismatches = 0;
  int                 cycle_count = 0;
  int                 src_idle_pct = 0;
  int                 sink_busy_pct = 0;
  bit                 hold_req = 1'b0;

  ordered_list_engine uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_word(in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word(out_word)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic out_word_t predict_list_op(in_word_t w);
    out_word_t r;
    int hit;
    r = '0;
    hit = -1;
    case (w.op)
      OP_PUSH_FRONT, OP_PUSH_BACK, OP_INSERT: begin
        if (shadow_list.size() >= LIST_CAP)
          r.status = STAT_FULL;
        else if (w.op == OP_INSERT && w.position > shadow_list.size())
          r.status = STAT_BAD_POS;
        else if (w.op == OP_PUSH_FRONT)
          shadow_list.push_front(w.item_value);
        else if (w.op == OP_PUSH_BACK)
          shadow_list.push_back(w.item_value);
        else
          shadow_list.insert(w.position, w.item_value);
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (shadow_list.size() == 0)
          r.status = STAT_EMPTY;
        else if (w.op == OP_POP_FRONT)
          r.data_out = shadow_list.pop_front();
        else
          r.data_out = shadow_list.pop_back();
      end
      OP_DELETE_AT, OP_READ: begin
        if (shadow_list.size() == 0)
          r.status = STAT_EMPTY;
        else if (w.position >= shadow_list.size())
          r.status = STAT_BAD_POS;
        else if (w.op == OP_DELETE_AT)
          shadow_list.delete(w.position);
        else
          r.data_out = shadow_list[w.position];
      end
      OP_DELETE_VALUE, OP_FIND: begin
        for (int i = 0; i < shadow_list.size(); i++) begin
          if (hit < 0 && shadow_list[i] == w.item_value)
            hit = i;
        end
        if (shadow_list.size() == 0)
          r.status = STAT_EMPTY;
        else if (hit < 0)
          r.status = STAT_NOT_FOUND;
        else if (w.op == OP_DELETE_VALUE)
          shadow_list.delete(hit);
        else
          r.found_index = 4'(hit);
      end
      default: ;
    endcase
    r.entry_count = 5'(shadow_list.size());
    return r;
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 9) == 0)
      return $urandom_range(8, 30);
    return $urandom_range(1, 3);
  endfunction

  function automatic logic [3:0] pick_op(op_mix_t mix);
    int r;
    r = $urandom_range(0, 99);
    if (r < 4)
      return 4'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
    if (r < 64 && mix == GROW_LIST)
      return GROW_OPS[$urandom_range(0, 2)];
    if (r < 64 && mix == DRAIN_LIST)
      return DRAIN_OPS[$urandom_range(0, 3)];
    return 4'($urandom_range(OP_PUSH_FRONT, OP_READ));
  endfunction

  // lean on values already stored so find and delete-by-value hit
  function automatic logic signed [31:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40 && shadow_list.size() > 0)
      return shadow_list[$urandom_range(0, shadow_list.size() - 1)];
    if (r < 60)
      return int'($urandom_range(0, 6)) - 3;
    if (r < 70)
      return r[0] ? 32'sh7FFFFFFF : 32'sh80000000;
    return $urandom;
  endfunction

  function automatic logic [4:0] pick_pos();
    if ($urandom_range(0, 4) == 0)
      return 5'($urandom_range(0, 31));
    return 5'($urandom_range(0, shadow_list.size()));
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    mismatches++;
    $display("%0t mismatch %s: got %0d want %0d", $time, what, got, want);
  endtask

  task automatic send_word(in_word_t w, bit fixed, out_word_t typed_res);
    out_word_t predicted;
    int gap;
    gap = ($urandom_range(0, 99) < src_idle_pct) ? gap_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (!(in_valid && !in_stall));
    predicted = predict_list_op(w);
    awaited_results.push_back(fixed ? typed_res : predicted);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (awaited_results.size() != 0);
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("ordered_list_engine_tb failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_results.size() == 0) begin
        report_mismatch("unexpected word, entry_count", out_word.entry_count, -1);
      end else begin
        head_result = awaited_results.pop_front();
        if (out_word.data_out !== head_result.data_out)
          report_mismatch("data_out", out_word.data_out, head_result.data_out);
        if (out_word.found_index !== head_result.found_index)
          report_mismatch("found_index", out_word.found_index, head_result.found_index);
        if (out_word.status !== head_result.status)
          report_mismatch("status", out_word.status, head_result.status);
        if (out_word.entry_count !== head_result.entry_count)
          report_mismatch("entry_count", out_word.entry_count, head_result.entry_count);
      end
    end
  end

  // result side back-pressure: random stalls plus one long hold on request
  initial begin
    int hold_left;
    int stall_left;
    hold_left = 0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if ($urandom_range(0, 99) < sink_busy_pct) begin
        stall_left = gap_len() - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    stim_row_t row;
    in_word_t  w;
    out_word_t typed_res;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    src_idle_pct = 25;
    sink_busy_pct = 25;
    for (int i = 0; i < NUM_ROWS; i++) begin
      row = DIRECTED_ROWS[i];
      w.op = row.op;
      w.item_value = row.val;
      w.position = row.pos;
      typed_res.data_out = row.data;
      typed_res.found_index = row.idx;
      typed_res.status = row.st;
      typed_res.entry_count = row.cnt;
      for (int k = 0; k < row.reps; k++)
        send_word(w, row.fixed, typed_res);
    end

    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 4)
        wait_drained();
      src_idle_pct = SRC_IDLE_PCT[ph];
      sink_busy_pct = SINK_BUSY_PCT[ph];
      if (ph == 2)
        hold_req = 1'b1;
      for (int k = 0; k < WORDS_PER_PHASE; k++) begin
        w.op = pick_op(PHASE_MIX[ph]);
        w.item_value = pick_value();
        w.position = pick_pos();
        send_word(w, 1'b0, '0);
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("ordered_list_engine_tb passed");
    else
      $display("ordered_list_engine_tb failed");
    $finish;
  end

endmodule
